// ===== design/ssdc_pkg.sv =====
// Shared types, constants and helpers for the servo sweep controller.
// No dependencies; imported by ssdc_step and the top level.
package ssdc_pkg;

  localparam int MAX_SPEED = 10;
  localparam int MIN_SPEED = 0;

  localparam logic [7:0] ANGLE_TOP       = 8'd180;
  localparam logic [7:0] IRRIGATE_RESET  = 8'd20;
  localparam logic [7:0] PAUSE_RESET     = 8'd60;

  localparam logic [4:0] SPEED_HI = 5'(MAX_SPEED);
  localparam logic [4:0] SPEED_LO = 5'(MIN_SPEED);

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_PAUSE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    FN_UPDATE    = 3'd0,
    FN_TICK      = 3'd1,
    FN_TOGGLE    = 3'd2,
    FN_SET_SPEED = 3'd3,
    FN_SPEED_UP  = 3'd4,
    FN_SPEED_DN  = 3'd5
  } func_t;

  typedef enum logic {
    CFG_IRRIGATE = 1'b0,
    CFG_PAUSE    = 1'b1
  } cfg_index_t;

  // Packed MSB first, so mode lands in the lowest bits of tdata.
  typedef struct packed {
    logic [3:0] speed;
    logic [6:0] step_delay_ms;
    logic       moved;
    logic       servo_enabled;
    logic [7:0] angle;
    logic [1:0] mode;
  } ssdc_result_t;

  // 10 * (MAX_SPEED - speed + 1), clamped to the 7-bit field.
  function automatic logic [6:0] step_delay(input logic [3:0] spd);
    int d;
    d = 10 * (MAX_SPEED - int'(spd) + 1);
    if (d > 127) d = 127;
    if (d < 0) d = 0;
    return 7'(d);
  endfunction

endpackage

// ===== design/ssdc_step.sv =====
// Controller state and per-beat next-state logic for the servo sweep controller.
// Depends on ssdc_pkg.
module ssdc_step import ssdc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_data,
  input  logic         fire,
  input  logic [2:0]   func,
  input  logic [3:0]   new_speed,
  output ssdc_result_t result
);

  mode_t      mode, mode_next;
  logic [7:0] angle, angle_next;
  logic       sweep_down, sweep_down_next;
  logic [3:0] speed, speed_next;
  logic [7:0] tick_count, tick_count_next;
  logic       stop_flag, stop_flag_next;
  logic [7:0] irrigate_ticks, pause_ticks;

  logic       moved;
  logic [7:0] tick_inc;
  logic [7:0] limit;
  logic [4:0] spd_req;
  logic       spd_try;
  logic       dir_down;

  always_ff @(posedge clk) begin
    if (rst) begin
      irrigate_ticks <= IRRIGATE_RESET;
      pause_ticks    <= PAUSE_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_IRRIGATE: irrigate_ticks <= cfg_data;
        CFG_PAUSE:    pause_ticks    <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_comb begin
    mode_next       = mode;
    angle_next      = angle;
    sweep_down_next = sweep_down;
    speed_next      = speed;
    tick_count_next = tick_count;
    stop_flag_next  = stop_flag;
    moved           = 1'b0;
    spd_req         = {1'b0, new_speed};
    spd_try         = 1'b0;
    tick_inc        = tick_count + 8'd1;
    limit           = (mode == MODE_ON) ? irrigate_ticks : pause_ticks;
    // reverse at either end before taking the step
    dir_down        = sweep_down ^ ((!sweep_down && angle >= ANGLE_TOP) ||
                                    (sweep_down && angle == 8'd0));

    case (func_t'(func))
      FN_UPDATE: begin
        if (mode == MODE_ON) begin
          if (stop_flag) begin
            mode_next = MODE_PAUSE;
          end else begin
            sweep_down_next = dir_down;
            angle_next      = dir_down ? angle - 8'd1 : angle + 8'd1;
            moved           = 1'b1;
          end
        end else if (mode == MODE_PAUSE && !stop_flag) begin
          mode_next = MODE_ON;
        end
      end
      FN_TICK: begin
        if (mode != MODE_OFF) begin
          if (tick_inc >= limit) begin
            tick_count_next = 8'd0;
            stop_flag_next  = (mode == MODE_ON);
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      FN_TOGGLE: begin
        tick_count_next = 8'd0;
        if (mode == MODE_ON) begin
          mode_next = MODE_OFF;
        end else begin
          mode_next      = MODE_ON;
          stop_flag_next = 1'b0;
        end
      end
      FN_SET_SPEED: begin
        spd_try = 1'b1;
      end
      FN_SPEED_UP: begin
        spd_req = {1'b0, speed} + 5'd1;
        spd_try = 1'b1;
      end
      FN_SPEED_DN: begin
        // below zero wraps to 31 in the 5-bit request: never in range
        spd_req = {1'b0, speed} - 5'd1;
        spd_try = (speed != 4'd0);
      end
      default: ;
    endcase

    if (spd_try && spd_req >= SPEED_LO && spd_req <= SPEED_HI) begin
      speed_next = spd_req[3:0];
    end

    result.mode          = mode_next;
    result.angle         = angle_next;
    result.servo_enabled = (mode_next != MODE_OFF);
    result.moved         = moved;
    result.step_delay_ms = moved ? step_delay(speed) : 7'd0;
    result.speed         = speed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_OFF;
      angle      <= 8'd0;
      sweep_down <= 1'b0;
      speed      <= 4'd0;
      tick_count <= 8'd0;
      stop_flag  <= 1'b0;
    end else if (fire) begin
      mode       <= mode_next;
      angle      <= angle_next;
      sweep_down <= sweep_down_next;
      speed      <= speed_next;
      tick_count <= tick_count_next;
      stop_flag  <= stop_flag_next;
    end
  end

endmodule

// ===== design/sweep_servo_duty_cycle_controller_top.sv =====
// Top level of the servo sweep controller: stream handshake and result register.
// Depends on ssdc_pkg and ssdc_step.
//
//  channel  | direction | beat contents
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | event: func, new_speed
//  m_axis   | out       | status: mode, angle, enable, moved, delay, speed
//  cfg      | in        | index 0 irrigate_ticks, index 1 pause_ticks
//
// One event per clock while the status output is not stalled. State updates at the accepting edge; the status
// beat is valid the next cycle from the result register.
// s_tready is high whenever the result register is empty or being drained,
// so a stalled output holds the input only while the status is not taken.
// rst is synchronous; controller state, config and m_tvalid return to their reset values (result_q is not reset).
module sweep_servo_duty_cycle_controller_top import ssdc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [2:0] func, [6:3] new_speed
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [1:0] mode, [9:2] angle, [10] servo_enabled,
                                 // [11] moved, [18:12] step_delay_ms, [22:19] speed
);

  ssdc_result_t result;
  ssdc_result_t result_q;
  logic         fire;

  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;

  ssdc_step u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .func      (s_tdata[2:0]),
    .new_speed (s_tdata[6:3]),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_q <= result;
    end
  end

  assign m_tdata = {1'b0, result_q};

endmodule

// ===== design/ssdc_checker.sv =====
// Port-level checks for the servo sweep controller, bound to the top level.
// Depends on sweep_servo_duty_cycle_controller_top port names.
module ssdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("status beat valid right after reset");

  a_accept_to_valid: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted event produced no status beat");

  a_enable_matches_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[10] == (m_tdata[1:0] != 2'd0)))
    else $error("servo_enabled disagrees with mode");

  a_delay_only_on_move: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11] ? (m_tdata[18:12] != 7'd0 && m_tdata[1:0] == 2'd1)
                              : (m_tdata[18:12] == 7'd0)))
    else $error("step delay inconsistent with moved flag");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled status beat changed");

endmodule

bind sweep_servo_duty_cycle_controller_top ssdc_checker u_ssdc_checker (.*);

// ===== bench/tb_sweep_servo_duty_cycle_controller_top.sv =====
// Self-checking bench for the servo sweep controller top level.
// Drives event beats and threshold writes, predicts every status beat, checks in order.
// Depends on ssdc_pkg and the RTL top; needs no files or arguments.
module tb_sweep_servo_duty_cycle_controller_top;
  import ssdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // func codes with no operation behind them
  localparam logic [2:0] FN_SPARE_6 = 3'd6;
  localparam logic [2:0] FN_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [3:0] new_speed;
    logic [2:0] func;
  } servo_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = 8'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [2:0] func, [6:3] new_speed
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // [1:0] mode, [9:2] angle, [10] servo_enabled,
                                 // [11] moved, [18:12] step_delay_ms, [22:19] speed

  sweep_servo_duty_cycle_controller_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // shadow of the controller state and thresholds
  mode_t      sh_mode = MODE_OFF;
  logic [7:0] sh_angle = 8'd0;
  logic       sh_down = 1'b0;
  logic [3:0] sh_speed = 4'd0;
  logic [7:0] sh_ticks = 8'd0;
  logic       sh_stop = 1'b0;
  logic [7:0] irrigate_limit = IRRIGATE_RESET;
  logic [7:0] pause_limit = PAUSE_RESET;

  servo_event_t event_q[$];
  ssdc_result_t status_q[$];

  int n_pushed = 0;
  int n_events = 0;
  int n_status = 0;
  int n_moves = 0;
  int n_bounces = 0;
  int n_pauses = 0;
  int n_settings = 1;
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int tx_gap = 0;
  int rx_hold = 0;
  logic in_fire = 1'b0;

  function automatic void apply_speed(int v);
    if (v >= MIN_SPEED && v <= MAX_SPEED) sh_speed = v[3:0];
  endfunction

  // advance the shadow state by one event and build the status it reports
  function automatic ssdc_result_t servo_advance(servo_event_t ev);
    ssdc_result_t r;
    logic [7:0] limit;
    int dly;
    r = '0;
    case (ev.func)
      FN_UPDATE: begin
        if (sh_mode == MODE_ON) begin
          if (sh_stop) begin
            sh_mode = MODE_PAUSE;
            n_pauses++;
          end else begin
            if ((!sh_down && sh_angle >= ANGLE_TOP) || (sh_down && sh_angle == 8'd0)) begin
              sh_down = ~sh_down;
              n_bounces++;
            end
            sh_angle = sh_down ? sh_angle - 8'd1 : sh_angle + 8'd1;
            r.moved = 1'b1;
            dly = 10 * (MAX_SPEED - int'(sh_speed) + 1);
            if (dly > 127) dly = 127;
            r.step_delay_ms = dly[6:0];
            n_moves++;
          end
        end else if (sh_mode == MODE_PAUSE && !sh_stop) begin
          sh_mode = MODE_ON;
        end
      end
      FN_TICK: begin
        if (sh_mode != MODE_OFF) begin
          limit = (sh_mode == MODE_ON) ? irrigate_limit : pause_limit;
          sh_ticks = sh_ticks + 8'd1;
          if (sh_ticks >= limit) begin
            sh_ticks = 8'd0;
            sh_stop = (sh_mode == MODE_ON);
          end
        end
      end
      FN_TOGGLE: begin
        if (sh_mode == MODE_ON) begin
          sh_mode = MODE_OFF;
        end else begin
          sh_mode = MODE_ON;
          sh_stop = 1'b0;
        end
        sh_ticks = 8'd0;
      end
      FN_SET_SPEED: apply_speed(int'(ev.new_speed));
      FN_SPEED_UP:  apply_speed(int'(sh_speed) + 1);
      FN_SPEED_DN:  apply_speed(int'(sh_speed) - 1);
      default: ;
    endcase
    r.mode = sh_mode;
    r.angle = sh_angle;
    r.servo_enabled = (sh_mode != MODE_OFF);
    r.speed = sh_speed;
    return r;
  endfunction

  function automatic int pick_gap(int pct);
    if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // sender: holds a beat until taken, then optionally idles
  always @(negedge clk) begin
    if (!s_tvalid || in_fire) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (event_q.size() > 0) begin
        s_tdata <= {1'b0, event_q.pop_front()};
        s_tvalid <= 1'b1;
        tx_gap = pick_gap(tx_idle_pct);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure plus long holds on request
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (holds_done < holds_asked && s_tvalid) begin
      holds_done++;
      rx_hold = $urandom_range(60, 100);
      m_tready <= 1'b0;
    end else if (rx_idle_pct > 0 && $urandom_range(0, 199) == 0) begin
      rx_hold = $urandom_range(10, 30);
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // monitor: check the status beat, then predict for the accepted event
  always @(posedge clk) begin
    ssdc_result_t got, want;
    if (!rst) begin
      in_fire <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got = ssdc_result_t'(m_tdata[22:0]);
        n_status++;
        if (status_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected status beat %h", m_tdata);
        end else begin
          want = status_q.pop_front();
          if (got.mode !== want.mode || got.angle !== want.angle ||
              got.servo_enabled !== want.servo_enabled || got.moved !== want.moved ||
              got.step_delay_ms !== want.step_delay_ms || got.speed !== want.speed) begin
            errors++;
            if (errors <= 10)
              $display("status %0d mismatch: exp mode %0d angle %0d en %0b moved %0b dly %0d spd %0d, got mode %0d angle %0d en %0b moved %0b dly %0d spd %0d",
                       n_status, want.mode, want.angle, want.servo_enabled, want.moved,
                       want.step_delay_ms, want.speed, got.mode, got.angle,
                       got.servo_enabled, got.moved, got.step_delay_ms, got.speed);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        status_q.push_back(servo_advance(servo_event_t'(s_tdata[6:0])));
        n_events++;
      end
    end
  end

  task automatic queue_event(input logic [2:0] fn, input logic [3:0] spd);
    servo_event_t ev;
    ev.func = fn;
    ev.new_speed = spd;
    event_q.push_back(ev);
    n_pushed++;
  endtask

  // wait until every event is taken and every status beat has come back
  task automatic drain();
    while (n_events != n_pushed || status_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_IRRIGATE) irrigate_limit = val;
    else pause_limit = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly update steps and ticks so the sweep gets far; rare toggles
  task automatic queue_random(input int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 999);
      if (r < 560)      queue_event(FN_UPDATE, 4'($urandom_range(0, 15)));
      else if (r < 760) queue_event(FN_TICK, 4'($urandom_range(0, 15)));
      else if (r < 780) queue_event(FN_TOGGLE, 4'($urandom_range(0, 15)));
      else if (r < 840) queue_event(FN_SET_SPEED, 4'($urandom_range(0, 15)));
      else if (r < 890) queue_event(FN_SPEED_UP, 4'($urandom_range(0, 15)));
      else if (r < 940) queue_event(FN_SPEED_DN, 4'($urandom_range(0, 15)));
      else if (r < 970) queue_event(FN_SPARE_6, 4'($urandom_range(0, 15)));
      else              queue_event(FN_SPARE_7, 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic run_phase(input logic [7:0] irr, input logic [7:0] pau, input int count,
                           input int tx_pct, input int rx_pct, input int holds);
    drain();
    write_reg(CFG_IRRIGATE, irr);
    write_reg(CFG_PAUSE, pau);
    n_settings++;
    @(posedge clk);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    holds_asked += holds;
    queue_random(count);
  endtask

  initial begin
    #10ms;
    $display("timeout waiting for status beats");
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: off-mode events, spare codes, speed limits, basic sweep
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    queue_event(FN_UPDATE, 4'd0);
    queue_event(FN_TICK, 4'd0);
    queue_event(FN_SPARE_6, 4'd15);
    queue_event(FN_SPARE_7, 4'd10);
    queue_event(FN_SET_SPEED, 4'd15);
    queue_event(FN_SET_SPEED, 4'd11);
    queue_event(FN_SET_SPEED, 4'd10);
    queue_event(FN_SPEED_UP, 4'd0);
    queue_event(FN_TOGGLE, 4'd0);
    queue_event(FN_UPDATE, 4'd0);
    queue_event(FN_SET_SPEED, 4'd0);
    queue_event(FN_SPEED_DN, 4'd0);
    queue_event(FN_UPDATE, 4'd0);
    queue_event(FN_SPEED_UP, 4'd0);
    queue_event(FN_TICK, 4'd0);
    queue_event(FN_TOGGLE, 4'd0);
    queue_event(FN_UPDATE, 4'd0);
    queue_event(FN_TOGGLE, 4'd0);
    queue_event(FN_UPDATE, 4'd0);
    queue_event(FN_SET_SPEED, 4'd5);
    queue_random(200);

    run_phase(8'd1, 8'd1, 200, 0, 0, 0);       // back-to-back, fastest pause cycling
    run_phase(8'd255, 8'd255, 300, 40, 40, 0); // long sweeps, heavy idling
    run_phase(8'd0, 8'd0, 100, 10, 10, 0);     // zero threshold: first tick trips
    run_phase(8'd7, 8'd3, 250, 0, 15, 2);      // receiver stalls while sender streams
    run_phase(8'd255, 8'd1, 250, 15, 25, 0);
    run_phase(8'd1, 8'd255, 200, 25, 15, 1);

    drain();
    repeat (8) @(posedge clk);
    $display("ran %0d events over %0d threshold settings; %0d status beats checked",
             n_events, n_settings, n_status);
    $display("sweep made %0d moves, %0d reversals, %0d pauses; %0d long holds",
             n_moves, n_bounces, n_pauses, holds_done);
    if (errors == 0 && status_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d status beats missing", errors, status_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ssdc_pkg.sv
design/ssdc_step.sv
design/sweep_servo_duty_cycle_controller_top.sv
design/ssdc_checker.sv
bench/tb_sweep_servo_duty_cycle_controller_top.sv
